### rtl/core/affine_transform_matrix_builder_macros.svh
// ----------------------------------------------------------------------------
// Affine transform matrix builder: assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TRANSFORM_MATRIX_BUILDER_MACROS_SVH
`define AFFINE_TRANSFORM_MATRIX_BUILDER_MACROS_SVH

// same-cycle implication
`define ATMB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("atmb assertion failed");

// next-cycle implication
`define ATMB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("atmb assertion failed");

`endif

### rtl/core/atmb_pkg.sv
// ----------------------------------------------------------------------------
// atmb_pkg
// Types, constants and the arctangent table of the matrix builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atmb_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 30;
    localparam int XYW              = 34;
    localparam int ZW               = 25;
    localparam int AW               = 15;
    localparam int RW               = 13;
    localparam int FULL_TURN        = 23040;
    localparam int QUARTER_TURN     = 5760;
    localparam int GAIN_Q30         = 652032874;

    typedef logic signed [XYW-1:0] xy_t;
    typedef logic signed [ZW-1:0]  zang_t;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } quad_t;

    typedef struct packed {
        logic signed [31:0] tx;
        logic signed [31:0] ty;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } atmb_side_t;

    typedef struct packed {
        xy_t        x;
        xy_t        y;
        zang_t      z;
        quad_t      quad;
        atmb_side_t side;
    } atmb_rot_t;

    localparam zang_t ATAN_TAB [0:ATAN_ENTRIES-1] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115,
        25'sd57,      25'sd29,      25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1,      25'sd0,
        25'sd0,       25'sd0,       25'sd0,      25'sd0,
        25'sd0,       25'sd0
    };

endpackage

### rtl/core/affine_transform_matrix_builder.sv
// Usage: one input word carries a translation (s_translate_x, s_translate_y),
// an angle in Q10.6 degrees (s_angle_deg) and a scale (s_scale_x, s_scale_y),
// all others Q16.16. One output word carries the six variable entries of the
// translate * rotate * scale matrix: m00, m01, m03, m10, m11, m13 (Q16.16).
// Both channels are valid/ready; a word moves when valid and ready are high.
// The pipeline has two angle stages, one CORDIC stage per step, then the fold,
// multiply and saturate stages. One word per cycle enters while m_ready is
// high; the whole pipeline advances as one, so a full pipe holds
// CORDIC_STEPS + 5 words. A stalled output (m_valid high, m_ready low)
// freezes every stage and drops s_ready; nothing is lost or repeated. Reset
// (aresetn low, synchronous) empties the pipeline; the block holds no other
// state and needs no warm-up.
// ----------------------------------------------------------------------------
// affine_transform_matrix_builder
// Pipelined 2-D translate/rotate/scale matrix builder with CORDIC sine/cosine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module affine_transform_matrix_builder
    import atmb_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_translate_x,
    input  logic signed [31:0] s_translate_y,
    input  logic signed [15:0] s_angle_deg,
    input  logic signed [31:0] s_scale_x,
    input  logic signed [31:0] s_scale_y,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_m00,
    output logic signed [31:0] m_m01,
    output logic signed [31:0] m_m03,
    output logic signed [31:0] m_m10,
    output logic signed [31:0] m_m11,
    output logic signed [31:0] m_m13
);

    logic              advance;
    atmb_side_t        side_in;
    atmb_rot_t         rot_chain [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] valid_chain;

    assign advance = m_ready || !m_valid;
    assign s_ready = advance;

    always_comb begin
        side_in.tx = s_translate_x;
        side_in.ty = s_translate_y;
        side_in.sx = s_scale_x;
        side_in.sy = s_scale_y;
    end

    atmb_angle_reduce u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (s_valid),
        .angle     (s_angle_deg),
        .side_in   (side_in),
        .out_valid (valid_chain[0]),
        .rot_out   (rot_chain[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        atmb_cordic_stage #(
            .STEP_IDX (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .in_valid  (valid_chain[i]),
            .rot_in    (rot_chain[i]),
            .out_valid (valid_chain[i+1]),
            .rot_out   (rot_chain[i+1])
        );
    end

    atmb_product u_product (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .in_valid  (valid_chain[CORDIC_STEPS]),
        .rot_in    (rot_chain[CORDIC_STEPS]),
        .out_valid (m_valid),
        .m00       (m_m00),
        .m01       (m_m01),
        .m03       (m_m03),
        .m10       (m_m10),
        .m11       (m_m11),
        .m13       (m_m13)
    );

endmodule

### rtl/core/atmb_angle_reduce.sv
// ----------------------------------------------------------------------------
// atmb_angle_reduce
// Two stages: wrap the angle into one turn, then split quadrant and residue
// and seed the rotation word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "affine_transform_matrix_builder_macros.svh"

module atmb_angle_reduce
    import atmb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_valid,
    input  logic signed [15:0] angle,
    input  atmb_side_t         side_in,
    output logic               out_valid,
    output atmb_rot_t          rot_out
);

    logic signed [17:0] ang_ext;
    logic signed [17:0] a_wide;
    logic [AW-1:0]      a_next;
    logic [AW-1:0]      a_reg;
    atmb_side_t         side_reg;
    logic               valid1_reg;

    quad_t              quad_next;
    logic [AW-1:0]      r_wide;
    logic [RW-1:0]      r_next;
    atmb_rot_t          rot_next;
    atmb_rot_t          rot_reg;
    logic               valid2_reg;

    always_comb begin
        ang_ext = {{2{angle[15]}}, angle};
        if (ang_ext < -18'sd23040) begin
            a_wide = ang_ext + 18'sd46080;
        end else if (ang_ext < 18'sd0) begin
            a_wide = ang_ext + 18'sd23040;
        end else if (ang_ext >= 18'sd23040) begin
            a_wide = ang_ext - 18'sd23040;
        end else begin
            a_wide = ang_ext;
        end
        a_next = a_wide[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (advance) begin
            valid1_reg <= in_valid;
        end
        if (advance) begin
            a_reg    <= a_next;
            side_reg <= side_in;
        end
    end

    always_comb begin
        if (a_reg >= AW'(3 * QUARTER_TURN)) begin
            quad_next = QUAD_270;
            r_wide    = a_reg - AW'(3 * QUARTER_TURN);
        end else if (a_reg >= AW'(2 * QUARTER_TURN)) begin
            quad_next = QUAD_180;
            r_wide    = a_reg - AW'(2 * QUARTER_TURN);
        end else if (a_reg >= AW'(QUARTER_TURN)) begin
            quad_next = QUAD_90;
            r_wide    = a_reg - AW'(QUARTER_TURN);
        end else begin
            quad_next = QUAD_0;
            r_wide    = a_reg;
        end
        r_next        = r_wide[RW-1:0];
        rot_next.x    = xy_t'(GAIN_Q30);
        rot_next.y    = '0;
        rot_next.z    = zang_t'({2'b00, r_next, 10'b0});
        rot_next.quad = quad_next;
        rot_next.side = side_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg <= 1'b0;
        end else if (advance) begin
            valid2_reg <= valid1_reg;
        end
        if (advance) begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = valid2_reg;
    assign rot_out   = rot_reg;

    `ATMB_ASSERT_IMPL(a_turn_range, valid1_reg, a_reg < AW'(FULL_TURN))
    `ATMB_ASSERT_IMPL(a_residue_range, valid2_reg, rot_reg.z < zang_t'(QUARTER_TURN * 1024))
    `ATMB_ASSERT_NEXT(a_stall_keeps, (valid2_reg && !advance), valid2_reg)

endmodule

### rtl/core/atmb_cordic_stage.sv
// ----------------------------------------------------------------------------
// atmb_cordic_stage
// One registered CORDIC rotation step with a fixed shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atmb_cordic_stage
    import atmb_pkg::*;
#(
    parameter int STEP_IDX = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      advance,
    input  logic      in_valid,
    input  atmb_rot_t rot_in,
    output logic      out_valid,
    output atmb_rot_t rot_out
);

    xy_t       x_cur;
    xy_t       y_cur;
    zang_t     z_cur;
    xy_t       dx;
    xy_t       dy;
    atmb_rot_t rot_next;
    atmb_rot_t rot_reg;
    logic      valid_reg;

    always_comb begin
        x_cur    = rot_in.x;
        y_cur    = rot_in.y;
        z_cur    = rot_in.z;
        dx       = y_cur >>> STEP_IDX;
        dy       = x_cur >>> STEP_IDX;
        rot_next = rot_in;
        if (z_cur >= 0) begin
            rot_next.x = x_cur - dx;
            rot_next.y = y_cur + dy;
            rot_next.z = z_cur - ATAN_TAB[STEP_IDX];
        end else begin
            rot_next.x = x_cur + dx;
            rot_next.y = y_cur - dy;
            rot_next.z = z_cur + ATAN_TAB[STEP_IDX];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
        if (advance) begin
            rot_reg <= rot_next;
        end
    end

    assign out_valid = valid_reg;
    assign rot_out   = rot_reg;

endmodule

### rtl/core/atmb_product.sv
// ----------------------------------------------------------------------------
// atmb_product
// Quadrant fold, four Q2.30 x Q16.16 products, then shift and saturate into
// the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "affine_transform_matrix_builder_macros.svh"

module atmb_product
    import atmb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               advance,
    input  logic               in_valid,
    input  atmb_rot_t          rot_in,
    output logic               out_valid,
    output logic signed [31:0] m00,
    output logic signed [31:0] m01,
    output logic signed [31:0] m03,
    output logic signed [31:0] m10,
    output logic signed [31:0] m11,
    output logic signed [31:0] m13
);

    function automatic logic signed [31:0] sat_q30(input logic signed [63:0] prod);
        logic signed [33:0] p;
        p = prod[63:30];
        if (p > 34'sh0_7FFF_FFFF) begin
            sat_q30 = 32'sh7FFF_FFFF;
        end else if (p < -34'sh0_8000_0000) begin
            sat_q30 = 32'sh8000_0000;
        end else begin
            sat_q30 = p[31:0];
        end
    endfunction

    xy_t                x_fin;
    xy_t                y_fin;
    xy_t                c_wide;
    xy_t                s_wide;
    xy_t                ns_wide;

    logic signed [31:0] c_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] ns_reg;
    atmb_side_t         side1_reg;
    logic               valid1_reg;

    logic signed [63:0] p00_reg;
    logic signed [63:0] p01_reg;
    logic signed [63:0] p10_reg;
    logic signed [63:0] p11_reg;
    logic signed [31:0] tx2_reg;
    logic signed [31:0] ty2_reg;
    logic               valid2_reg;

    logic signed [31:0] m00_reg;
    logic signed [31:0] m01_reg;
    logic signed [31:0] m03_reg;
    logic signed [31:0] m10_reg;
    logic signed [31:0] m11_reg;
    logic signed [31:0] m13_reg;
    logic               valid3_reg;

    always_comb begin
        x_fin = rot_in.x;
        y_fin = rot_in.y;
        case (rot_in.quad)
            QUAD_0: begin
                c_wide = x_fin;
                s_wide = y_fin;
            end
            QUAD_90: begin
                c_wide = -y_fin;
                s_wide = x_fin;
            end
            QUAD_180: begin
                c_wide = -x_fin;
                s_wide = -y_fin;
            end
            default: begin
                c_wide = y_fin;
                s_wide = -x_fin;
            end
        endcase
        ns_wide = -s_wide;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end else if (advance) begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
        if (advance) begin
            c_reg     <= c_wide[31:0];
            s_reg     <= s_wide[31:0];
            ns_reg    <= ns_wide[31:0];
            side1_reg <= rot_in.side;

            p00_reg <= 64'(c_reg) * 64'(side1_reg.sx);
            p01_reg <= 64'(ns_reg) * 64'(side1_reg.sy);
            p10_reg <= 64'(s_reg) * 64'(side1_reg.sx);
            p11_reg <= 64'(c_reg) * 64'(side1_reg.sy);
            tx2_reg <= side1_reg.tx;
            ty2_reg <= side1_reg.ty;

            m00_reg <= sat_q30(p00_reg);
            m01_reg <= sat_q30(p01_reg);
            m10_reg <= sat_q30(p10_reg);
            m11_reg <= sat_q30(p11_reg);
            m03_reg <= tx2_reg;
            m13_reg <= ty2_reg;
        end
    end

    assign out_valid = valid3_reg;
    assign m00       = m00_reg;
    assign m01       = m01_reg;
    assign m03       = m03_reg;
    assign m10       = m10_reg;
    assign m11       = m11_reg;
    assign m13       = m13_reg;

    `ATMB_ASSERT_IMPL(a_trig_no_min, valid1_reg, (c_reg != 32'sh8000_0000) && (s_reg != 32'sh8000_0000))

endmodule
